[rtl/core/sine_tone_generator_assert.svh]
// Assertion helpers for the tone generator.
// Both expect clk and arst_n in the enclosing scope.
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define STG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define STG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/stg_pkg.sv]
`timescale 1ns / 1ps

package stg_pkg;

	// Register map, index is paddr[3:2]
	localparam logic [1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
	localparam logic [1:0] REG_FORMAT     = 2'd2;

	// Reset values: 440 Hz at 44.1 kHz, amplitude 2048, mono 16-bit
	localparam logic [31:0] PHASE_STEP_RST = 32'd42852281;
	localparam logic [14:0] AMPLITUDE_RST  = 15'd2048;
	localparam logic [1:0]  FORMAT_RST     = 2'd1;

	// Channel formats
	localparam logic [1:0] FMT_MONO8    = 2'd0;
	localparam logic [1:0] FMT_MONO16   = 2'd1;
	localparam logic [1:0] FMT_STEREO8  = 2'd2;
	localparam logic [1:0] FMT_STEREO16 = 2'd3;

	// Q30 unit and Taylor coefficients of sin(pi/2 * x)
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [30:0] COEF_1  = 31'd1686629713;
	localparam logic [30:0] COEF_3  = 31'd693598668;
	localparam logic [30:0] COEF_5  = 31'd85569306;
	localparam logic [30:0] COEF_7  = 31'd5026995;
	localparam logic [30:0] COEF_9  = 31'd172272;

	// Quarter-wave argument handed to the sine pipeline
	typedef struct packed {
		logic        neg; // lower half of the wave
		logic [30:0] x;   // Q30, 0 .. 2^30
	} sine_arg_t;

endpackage

[rtl/core/stg_sine_pipe.sv]
`timescale 1ns / 1ps

// Seven-stage quarter-wave sine: square, four Horner steps, final product
// with clamp and saturation. One multiplier per stage after the first.
module stg_sine_pipe
	import stg_pkg::*;
#(
	parameter int SINE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sine_arg_t            in_arg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_neg,
	output logic [SINE_BITS-2:0] out_mag
);

	localparam int NSTG = 7;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] ld;

	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0] y_s2, y_s3, y_s4, y_s5;
	logic [30:0] p_s3, p_s4, p_s5, p_s6;
	logic [SINE_BITS-2:0] mag_s7;

	logic [61:0] sq_prod, h3_prod, h4_prod, h5_prod, h6_prod, fin_prod;
	logic [30:0] q_clamp;
	logic [SINE_BITS-1:0] mag_raw;
	logic [SINE_BITS-2:0] mag_sat;

	// Load chain: a stage loads when empty or when it moves on
	always_comb begin
		ld[NSTG] = !vld_q[NSTG] || out_ready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	assign in_ready  = ld[1];
	assign out_valid = vld_q[NSTG];
	assign out_neg   = neg_s7;
	assign out_mag   = mag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Products; every value kept is below 2^31, so [60:30] is the shift by 30
	assign sq_prod  = 62'(x_s1) * 62'(x_s1);
	assign h3_prod  = 62'(COEF_9) * 62'(y_s2);
	assign h4_prod  = 62'(p_s3) * 62'(y_s3);
	assign h5_prod  = 62'(p_s4) * 62'(y_s4);
	assign h6_prod  = 62'(p_s5) * 62'(y_s5);
	assign fin_prod = 62'(p_s6) * 62'(x_s6);

	// Clamp to one, drop to SINE_BITS, saturate to the positive maximum
	always_comb begin
		q_clamp = (fin_prod[60:30] > Q30_ONE) ? Q30_ONE : fin_prod[60:30];
		mag_raw = q_clamp[30:31-SINE_BITS];
		mag_sat = mag_raw[SINE_BITS-1] ? '1 : mag_raw[SINE_BITS-2:0];
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			neg_s1 <= in_arg.neg;
			x_s1   <= in_arg.x;
		end
		if (ld[2]) begin
			neg_s2 <= neg_s1;
			x_s2   <= x_s1;
			y_s2   <= sq_prod[60:30];
		end
		if (ld[3]) begin
			neg_s3 <= neg_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			p_s3   <= COEF_7 - h3_prod[60:30];
		end
		if (ld[4]) begin
			neg_s4 <= neg_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			p_s4   <= COEF_5 - h4_prod[60:30];
		end
		if (ld[5]) begin
			neg_s5 <= neg_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			p_s5   <= COEF_3 - h5_prod[60:30];
		end
		if (ld[6]) begin
			neg_s6 <= neg_s5;
			x_s6   <= x_s5;
			p_s6   <= COEF_1 - h6_prod[60:30];
		end
		if (ld[7]) begin
			neg_s7 <= neg_s6;
			mag_s7 <= mag_sat;
		end
	end

`include "sine_tone_generator_assert.svh"

	`STG_ASSERT_IMP(a_x_range, vld_q[1], x_s1 <= Q30_ONE)
	`STG_ASSERT_IMP(a_h3_range, vld_q[3], (p_s3 <= COEF_7) && (p_s3 >= COEF_7 - COEF_9))
	`STG_ASSERT_NXT(a_out_hold, vld_q[NSTG] && !out_ready, vld_q[NSTG] && $stable(mag_s7))

endmodule

[rtl/core/sine_tone_generator.sv]
`timescale 1ns / 1ps

// Channel   Dir  Bits                 Contents
// s_*       in   tdata[7:0]           tick in bit 0
// m_*       out  tdata[39:0]          first, second, bytes in frame
// APB       in   paddr[3:0], 32-bit   phase_step, amplitude, channel_format
//
// One beat per cycle in and out while the receiver does not stall; an accepted
// tick reaches its frame through the seven-stage polynomial sine pipeline and
// then the scale/pack stage. A tick of zero is taken and makes no frame.
// Stages advance independently, so bubbles are squeezed out under stalls.
// Reset clears the phase to zero and loads the register defaults.
module sine_tone_generator
	import stg_pkg::*;
#(
	parameter int PHASE_BITS = 32,
	parameter int SINE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] first_channel, [31:16] second_channel,
	                               // [34:32] bytes_in_frame, [39:35] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int STEP_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;
	localparam int PROD_W = 14 + SINE_BITS;

	logic [31:0] step_q;
	logic [14:0] amp_q;
	logic [1:0]  fmt_q;
	logic [PHASE_BITS-1:0] phase_q;

	logic cfg_wr;
	logic tick_acc;
	logic [STEP_W-1:0] step_w;
	logic [PHASE_BITS+27:0] frac_ext;
	logic [29:0] x_frac;
	sine_arg_t arg;

	logic pipe_valid, pipe_ready, pipe_neg;
	logic [SINE_BITS-2:0] pipe_mag;
	logic out_ld;

	logic [PROD_W-1:0] scale_prod;
	logic [14:0] scaled;
	logic [15:0] sample_raw, sample_fmt;
	logic [2:0]  bytes_nxt;

	logic        vld_s8;
	logic [15:0] first_s8, second_s8;
	logic [2:0]  bytes_s8;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= PHASE_STEP_RST;
			amp_q  <= AMPLITUDE_RST;
			fmt_q  <= FORMAT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PHASE_STEP: step_q <= pwdata;
				REG_AMPLITUDE:  amp_q  <= pwdata[14:0];
				REG_FORMAT:     fmt_q  <= pwdata[1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PHASE_STEP: prdata = step_q;
			REG_AMPLITUDE:  prdata = {17'd0, amp_q};
			REG_FORMAT:     prdata = {30'd0, fmt_q};
			default:        prdata = '0;
		endcase
	end

	// Phase accumulator, advanced after each frame's phase is taken
	assign tick_acc = s_tvalid && s_tready && s_tdata[0];
	assign step_w   = STEP_W'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (tick_acc) begin
			phase_q <= phase_q + step_w[PHASE_BITS-1:0];
		end
	end

	// Quadrant fold: fraction aligned to Q30, mirrored in odd quadrants
	assign frac_ext = {phase_q[PHASE_BITS-3:0], 30'd0};
	assign x_frac   = frac_ext[PHASE_BITS+27:PHASE_BITS-2];
	always_comb begin
		arg.neg = phase_q[PHASE_BITS-1];
		arg.x   = phase_q[PHASE_BITS-2] ? (Q30_ONE - {1'b0, x_frac}) : {1'b0, x_frac};
	end

	assign s_tready = pipe_ready;

	stg_sine_pipe #(
		.SINE_BITS(SINE_BITS)
	) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid && s_tdata[0]),
		.in_ready (pipe_ready),
		.in_arg   (arg),
		.out_valid(pipe_valid),
		.out_ready(out_ld),
		.out_neg  (pipe_neg),
		.out_mag  (pipe_mag)
	);

	// Scale, sign and pack for the channel format
	assign scale_prod = PROD_W'(amp_q) * PROD_W'(pipe_mag);
	assign scaled     = scale_prod[PROD_W-1:SINE_BITS-1];

	always_comb begin
		sample_raw = pipe_neg ? (16'd0 - {1'b0, scaled}) : {1'b0, scaled};
		// 8-bit formats keep the low byte, sign-extended
		sample_fmt = fmt_q[0] ? sample_raw : {{8{sample_raw[7]}}, sample_raw[7:0]};
		unique case (fmt_q)
			FMT_MONO8:    bytes_nxt = 3'd1;
			FMT_MONO16:   bytes_nxt = 3'd2;
			FMT_STEREO8:  bytes_nxt = 3'd2;
			FMT_STEREO16: bytes_nxt = 3'd4;
			default:      bytes_nxt = 3'd2;
		endcase
	end

	// Output register
	assign out_ld = !vld_s8 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (out_ld) begin
			vld_s8 <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			first_s8  <= sample_fmt;
			second_s8 <= fmt_q[1] ? sample_fmt : 16'd0;
			bytes_s8  <= bytes_nxt;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {5'd0, bytes_s8, second_s8, first_s8};

`include "sine_tone_generator_assert.svh"

	`STG_ASSERT_NXT(a_phase_hold, !tick_acc, $stable(phase_q))
	`STG_ASSERT_IMP(a_ready_chain, m_tready, s_tready)
	`STG_ASSERT_IMP(a_bytes_legal, vld_s8, (bytes_s8 == 3'd1) || (bytes_s8 == 3'd2) || (bytes_s8 == 3'd4))

endmodule

[bench/tone_frame_checker.sv]
`timescale 1ns / 1ps

module tone_frame_checker
	import stg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [15:0] first_channel, [31:16] second_channel,
	                               // [34:32] bytes_in_frame, [39:35] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          frames_due
);

	typedef struct packed {
		logic [15:0] first_channel;
		logic [15:0] second_channel;
		logic [2:0]  bytes_in_frame;
	} tone_frame_t;

	// Shadow copy of the block's registers and phase
	logic [31:0] step_cfg;
	logic [14:0] amp_cfg;
	logic [1:0]  fmt_cfg;
	logic [31:0] phase_acc;

	tone_frame_t frame_q[$];

	// Frame for one tick: fixed-point quarter-wave sine, scale, pack
	function automatic tone_frame_t synth_frame(input logic [31:0] phase,
		input logic [14:0] amp, input logic [1:0] fmt);
		tone_frame_t f;
		logic [1:0]  quad;
		logic [63:0] x, y, p, mag, scaled;
		logic [15:0] sample;
		quad = phase[31:30];
		x = {34'd0, phase[29:0]};
		if (quad[0]) begin
			x = 64'(Q30_ONE) - x;
		end
		// Horner form of the odd polynomial, every product truncated
		y = (x * x) >> 30;
		p = 64'(COEF_9);
		p = 64'(COEF_7) - ((p * y) >> 30);
		p = 64'(COEF_5) - ((p * y) >> 30);
		p = 64'(COEF_3) - ((p * y) >> 30);
		p = 64'(COEF_1) - ((p * y) >> 30);
		p = (p * x) >> 30;
		if (p > 64'(Q30_ONE)) begin
			p = 64'(Q30_ONE);
		end
		mag = p >> 15;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		scaled = (64'(amp) * mag) >> 15;
		sample = quad[1] ? 16'(64'd0 - scaled) : scaled[15:0];
		// 8-bit formats keep the low byte, sign-extended
		if (!fmt[0]) begin
			sample = {{8{sample[7]}}, sample[7:0]};
		end
		f.first_channel  = sample;
		f.second_channel = fmt[1] ? sample : 16'd0;
		case (fmt)
			FMT_MONO8:    f.bytes_in_frame = 3'd1;
			FMT_STEREO16: f.bytes_in_frame = 3'd4;
			default:      f.bytes_in_frame = 3'd2;
		endcase
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tone_frame_t got, want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			step_cfg   <= PHASE_STEP_RST;
			amp_cfg    <= AMPLITUDE_RST;
			fmt_cfg    <= FORMAT_RST;
			phase_acc  <= 32'd0;
			frame_q.delete();
			fail_count <= 0;
			frames_due <= 0;
		end else begin
			// Input beat: a tick of one makes a frame and moves the phase
			if (s_tvalid && s_tready && s_tdata[0]) begin
				frame_q.push_back(synth_frame(phase_acc, amp_cfg, fmt_cfg));
				phase_acc <= phase_acc + step_cfg;
			end

			// Register write; the spare index is ignored
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PHASE_STEP: step_cfg <= pwdata;
					REG_AMPLITUDE:  amp_cfg  <= pwdata[14:0];
					REG_FORMAT:     fmt_cfg  <= pwdata[1:0];
					default: ;
				endcase
			end

			// Output beat against the oldest expected frame
			if (m_tvalid && m_tready) begin
				got.first_channel  = m_tdata[15:0];
				got.second_channel = m_tdata[31:16];
				got.bytes_in_frame = m_tdata[34:32];
				if (frame_q.size() == 0) begin
					$error("frame with no tick pending: %h", m_tdata);
					errs++;
				end else begin
					want = frame_q.pop_front();
					if (got.first_channel !== want.first_channel) begin
						$error("first_channel: expected %0d, actual %0d",
							$signed(want.first_channel), $signed(got.first_channel));
						errs++;
					end
					if (got.second_channel !== want.second_channel) begin
						$error("second_channel: expected %0d, actual %0d",
							$signed(want.second_channel), $signed(got.second_channel));
						errs++;
					end
					if (got.bytes_in_frame !== want.bytes_in_frame) begin
						$error("bytes_in_frame: expected %0d, actual %0d",
							want.bytes_in_frame, got.bytes_in_frame);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			frames_due <= frame_q.size();
		end
	end

endmodule

[bench/sine_tone_generator_tb.sv]
`timescale 1ns / 1ps

module sine_tone_generator_tb
	import stg_pkg::*;
();

	localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped register index
	localparam int SETTLE_CYCLES = 16;          // beyond the pipeline latency
	localparam int IDLE_LIMIT    = 1000;        // cycles with no beat and no register access
	localparam int PHASES        = 6;
	localparam int PHASE_TICKS   = 200;
	localparam int HOLD_AT       = 725;         // ticks offered before the long hold
	localparam int HOLD_CYCLES   = 200;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = 4'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int frames_due;
	int sent_count = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_done = 1'b0;

	sine_tone_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tone_frame_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .frames_due(frames_due)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int idle_pct();
		return calm ? 0 : 12;
	endfunction

	// Offer one tick beat, after a random gap
	task automatic offer_tick(input logic tick);
		while ($urandom_range(99) < idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, tick};
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// Stop offering, wait for every frame, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycle, then the bus returns to idle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold once the sender is well along
	initial begin
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct());
			end
		end
	end

	// Watchdog on cycles with no beat and no register access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [31:0] value;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: first frame is the sine of zero; a zero tick in between
		offer_tick(1'b1);
		offer_tick(1'b1);
		offer_tick(1'b0);
		offer_tick(1'b1);
		settle();

		// Quarter-turn steps at full scale in stereo 16-bit, so frames cover every quadrant
		reg_write(REG_PHASE_STEP, 32'h4000_0000);
		reg_write(REG_AMPLITUDE, 32'hFFFF_FFFF);
		reg_write(REG_FORMAT, {30'd0, FMT_STEREO16});
		repeat (5) offer_tick(1'b1);
		settle();

		// Byte wrap in both 8-bit formats; upper format bits are dropped
		reg_write(REG_FORMAT, {30'd0, FMT_MONO8});
		repeat (4) offer_tick(1'b1);
		offer_tick(1'b0);
		settle();
		reg_write(REG_FORMAT, {30'h3FFF_FFFF, FMT_STEREO8});
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		repeat (4) offer_tick(1'b1);
		settle();

		// Largest step with silence, then no step with the smallest nonzero amplitude
		reg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
		reg_write(REG_AMPLITUDE, 32'd0);
		reg_write(REG_FORMAT, {30'd0, FMT_MONO16});
		repeat (3) offer_tick(1'b1);
		settle();
		reg_write(REG_PHASE_STEP, 32'd0);
		reg_write(REG_AMPLITUDE, 32'd1);
		repeat (2) offer_tick(1'b1);
		settle();

		// Random phases, each under fresh register values
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(3))
				0: value = $urandom_range(65535);
				1: value = 32'hFFFF_FFFF - $urandom_range(65535);
				default: value = $urandom;
			endcase
			reg_write(REG_PHASE_STEP, value);
			value = $urandom;
			if ($urandom_range(2) == 0) begin
				value[14:0] = 15'h7FFF;
			end
			reg_write(REG_AMPLITUDE, value);
			reg_write(REG_FORMAT, $urandom);
			if ($urandom_range(1) == 0) begin
				reg_write(REG_SPARE, $urandom);
			end
			calm = (ph == 2);
			repeat (PHASE_TICKS) offer_tick($urandom_range(99) >= 10);
			settle();
		end
		calm = 1'b0;

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/stg_pkg.sv
rtl/core/stg_sine_pipe.sv
rtl/core/sine_tone_generator.sv
bench/tone_frame_checker.sv
bench/sine_tone_generator_tb.sv
